[rtl/assert_macros.svh]
// Assertion helpers used by the hash top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is held.
`define RXMH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("rxmh assertion failed");

// Check that a condition never holds, off while reset is held.
`define RXMH_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("rxmh forbidden condition seen");

`endif

[rtl/rxmh_pkg.sv]
package rxmh_pkg;

  localparam logic [63:0] GOLDEN_MIX = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] WORD_MUL   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] TAIL_MUL   = 64'h94D049BB133111EB;
  localparam int unsigned FINAL_SHIFT = 31;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WMUL,
    ST_TMUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic logic [63:0] rotl27(input logic [63:0] x);
    rotl27 = {x[36:0], x[63:37]};
  endfunction

  function automatic logic [63:0] rotl13(input logic [63:0] x);
    rotl13 = {x[50:0], x[63:51]};
  endfunction

endpackage

[rtl/rxmh_mul.sv]
module rxmh_mul (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  output logic [63:0]          prod,
  output rxmh_pkg::mul_stat_t  stat
);

  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] pp;

  always_comb begin
    case (step_r)
      2'd0: begin
        op_x = a_r[31:0];
        op_y = b_r[31:0];
      end
      2'd1: begin
        op_x = a_r[31:0];
        op_y = b_r[63:32];
      end
      default: begin
        op_x = a_r[63:32];
        op_y = b_r[31:0];
      end
    endcase
    pp = {32'd0, op_x} * {32'd0, op_y};
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      step_nxt = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (step_r == 2'd0) begin
        acc_nxt = pp;
      end else begin
        acc_nxt = {acc_r[63:32] + pp[31:0], acc_r[31:0]};
      end
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd2) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    acc_r  <= acc_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/rotate_xor_multiply_hash64.sv]
// Streaming 64-bit rotate-xor-multiply hash, one message byte per transfer.
// in_*  : message bytes; in_tlast marks the final item, in_tuser marks an
//         item with no byte (an empty message is one such item with tlast).
// cfg_* : seed write, always ready; a new seed takes effect at the next
//         message start. Write it only while the block is idle.
// out_* : one 64-bit hash per message, after its last item.
// A byte that does not complete a word only enters the word buffer. The
// eighth byte of a word starts the 64x64 fold multiply, run as three
// 32x32 partial products on one shared multiplier before the result is
// handed back. The last item starts the tail multiply, whose result is
// registered and then loaded into the output register; when the last byte
// also completes a word, the tail multiply follows the fold multiply.
// in_tready is low while the multiplier works or a result waits to load.
// The output register holds one result; a new message may stream in while
// it waits, and a second result stalls the input until out_tready frees it.
// Reset (rst_n low, synchronous) clears the seed to zero, drops any pending
// result and opens a fresh message.
`include "assert_macros.svh"

module rotate_xor_multiply_hash64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  input  logic        in_tuser,   // [0] no_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [63:0] hash_value
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_data
);

  rxmh_pkg::state_t    state_r, state_nxt;
  rxmh_pkg::mul_stat_t mul_stat;

  logic [63:0] seed_r, seed_nxt;
  logic [63:0] hash_r, hash_nxt;
  logic [55:0] buf_r, buf_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        start_r, start_nxt;
  logic        pend_r, pend_nxt;
  logic [63:0] res_r, res_nxt;
  logic [63:0] odata_r, odata_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic        in_xfer;
  logic        fold;
  logic        emit_go;
  logic [63:0] h0;
  logic [55:0] buf0;
  logic [2:0]  cnt0;
  logic [55:0] buf_ins;
  logic [63:0] word;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic [63:0] mul_prod;

  rxmh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  assign in_tready  = (state_r == rxmh_pkg::ST_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign emit_go    = !ovalid_r || out_tready;

  always_comb begin
    h0      = start_r ? (seed_r ^ rxmh_pkg::GOLDEN_MIX) : hash_r;
    buf0    = start_r ? 56'd0 : buf_r;
    cnt0    = start_r ? 3'd0 : cnt_r;
    fold    = !in_tuser && (cnt0 == 3'd7);
    word    = {in_tdata, buf0};
    buf_ins = buf0;
    if (!in_tuser) begin
      buf_ins = buf0 | ({48'd0, in_tdata} << {cnt0, 3'b000});
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rxmh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (fold) begin
            state_nxt = rxmh_pkg::ST_WMUL;
          end else if (in_tlast) begin
            state_nxt = rxmh_pkg::ST_TMUL;
          end
        end
      end
      rxmh_pkg::ST_WMUL: begin
        if (mul_stat.done) begin
          state_nxt = pend_r ? rxmh_pkg::ST_TMUL : rxmh_pkg::ST_IDLE;
        end
      end
      rxmh_pkg::ST_TMUL: begin
        if (mul_stat.done) begin
          state_nxt = rxmh_pkg::ST_EMIT;
        end
      end
      rxmh_pkg::ST_EMIT: begin
        if (emit_go) begin
          state_nxt = rxmh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rxmh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    seed_nxt   = cfg_valid ? cfg_data : seed_r;
    hash_nxt   = hash_r;
    buf_nxt    = buf_r;
    cnt_nxt    = cnt_r;
    start_nxt  = start_r;
    pend_nxt   = pend_r;
    res_nxt    = res_r;
    odata_nxt  = odata_r;
    ovalid_nxt = ovalid_r && !out_tready;
    mul_start  = 1'b0;
    mul_a      = rxmh_pkg::rotl13(mul_prod);
    mul_b      = rxmh_pkg::TAIL_MUL;
    case (state_r)
      rxmh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          hash_nxt  = h0;
          start_nxt = in_tlast;
          pend_nxt  = in_tlast;
          mul_start = fold || in_tlast;
          if (fold) begin
            mul_a   = rxmh_pkg::rotl27(h0 ^ word);
            mul_b   = rxmh_pkg::WORD_MUL;
            buf_nxt = 56'd0;
            cnt_nxt = 3'd0;
          end else begin
            mul_a   = rxmh_pkg::rotl13(h0 ^ {8'd0, buf_ins});
            buf_nxt = buf_ins;
            cnt_nxt = in_tuser ? cnt0 : cnt0 + 3'd1;
          end
        end
      end
      rxmh_pkg::ST_WMUL: begin
        if (mul_stat.done) begin
          hash_nxt  = mul_prod;
          mul_start = pend_r;
        end
      end
      rxmh_pkg::ST_TMUL: begin
        if (mul_stat.done) begin
          res_nxt = mul_prod ^ (mul_prod >> rxmh_pkg::FINAL_SHIFT);
        end
      end
      rxmh_pkg::ST_EMIT: begin
        if (emit_go) begin
          odata_nxt  = res_r;
          ovalid_nxt = 1'b1;
          hash_nxt   = res_r;
        end
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    hash_r  <= hash_nxt;
    buf_r   <= buf_nxt;
    cnt_r   <= cnt_nxt;
    res_r   <= res_nxt;
    odata_r <= odata_nxt;
    if (!rst_n) begin
      state_r  <= rxmh_pkg::ST_IDLE;
      seed_r   <= 64'd0;
      start_r  <= 1'b1;
      pend_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      seed_r   <= seed_nxt;
      start_r  <= start_nxt;
      pend_r   <= pend_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  `RXMH_NEVER(a_busy_when_free, clk, rst_n,
    mul_stat.busy && (state_r == rxmh_pkg::ST_IDLE || state_r == rxmh_pkg::ST_EMIT))
  `RXMH_ASSERT(a_done_in_mul_state, clk, rst_n,
    mul_stat.done |-> (state_r == rxmh_pkg::ST_WMUL || state_r == rxmh_pkg::ST_TMUL))
  `RXMH_ASSERT(a_emit_loads_out, clk, rst_n,
    (state_r == rxmh_pkg::ST_EMIT && emit_go) |=> (ovalid_r && out_tdata == $past(res_r)))

endmodule

[sim/tb_top.sv]
module tb_top;

  localparam logic [63:0] SEED_MIX   = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] FOLD_MUL   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] FINISH_MUL = 64'h94D049BB133111EB;
  localparam int          FOLD_ROT   = 27;
  localparam int          FINISH_ROT = 13;
  localparam int          XOR_SHIFT  = 31;
  localparam int          SETTLE_CYCLES = 16;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_t;

  typedef struct {
    bit          is_seed_write;
    bit          wait_idle;
    logic [63:0] seed_value;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        no_data;
  } msg_item_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data   = '0;

  msg_item_t   pending_items[$];
  logic [63:0] expected_hashes[$];
  int          error_count = 0;

  // predictor state
  logic [63:0] model_seed    = '0;
  logic [63:0] running_hash  = '0;
  logic [55:0] partial_word  = '0;
  logic [2:0]  partial_count = '0;
  bit          msg_start     = 1'b1;

  // handshake bookkeeping
  bit          in_took  = 1'b0;
  bit          cfg_took = 1'b0;
  int          quiet_cycles = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_mode_left = 0;
  int          rx_holdoff = 0;

  rotate_xor_multiply_hash64 u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int r);
    return (x << r) | (x >> (64 - r));
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("ERROR %s: got %h expected %h", what, got, want);
    error_count++;
  endtask

  task automatic hash_step(input logic [7:0] data_byte, input logic last_byte,
                           input logic no_data);
    logic [63:0] h;
    if (msg_start) begin
      running_hash  = model_seed ^ SEED_MIX;
      partial_word  = '0;
      partial_count = '0;
      msg_start     = 1'b0;
    end
    if (!no_data) begin
      if (partial_count == 3'd7) begin
        h = running_hash ^ {data_byte, partial_word};
        running_hash  = rotl64(h, FOLD_ROT) * FOLD_MUL;
        partial_word  = '0;
        partial_count = '0;
      end else begin
        partial_word[partial_count*8 +: 8] = data_byte;
        partial_count++;
      end
    end
    if (last_byte) begin
      h = running_hash ^ {8'h00, partial_word};
      h = rotl64(h, FINISH_ROT) * FINISH_MUL;
      h = h ^ (h >> XOR_SHIFT);
      running_hash = h;
      expected_hashes.push_back(h);
      partial_word  = '0;
      partial_count = '0;
      msg_start     = 1'b1;
    end
  endtask

  task automatic push_byte(input logic [7:0] data_byte, input logic last_byte,
                           input logic no_data);
    msg_item_t it;
    it = '{default: '0};
    it.data_byte = data_byte;
    it.last_byte = last_byte;
    it.no_data   = no_data;
    pending_items.push_back(it);
  endtask

  task automatic push_seed(input logic [63:0] value);
    msg_item_t it;
    it = '{default: '0};
    it.is_seed_write = 1'b1;
    it.seed_value    = value;
    pending_items.push_back(it);
  endtask

  task automatic push_pause();
    msg_item_t it;
    it = '{default: '0};
    it.wait_idle = 1'b1;
    pending_items.push_back(it);
  endtask

  // monitor and predictor: sample at the rising edge
  always @(posedge clk) begin
    logic [63:0] want;
    in_took  <= in_tvalid && in_tready;
    cfg_took <= cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("unexpected hash_value", out_tdata, '0);
        end else begin
          want = expected_hashes.pop_front();
          if (out_tdata !== want)
            report_mismatch("hash_value", out_tdata, want);
        end
      end
      if (cfg_valid && cfg_ready)
        model_seed = cfg_data;
      if (in_tvalid && in_tready)
        hash_step(in_tdata, in_tlast, in_tuser);
      if (expected_hashes.size() == 0 && !in_tvalid && !cfg_valid)
        quiet_cycles++;
      else
        quiet_cycles = 0;
    end
  end

  // sender: bursts and gaps, change at the falling edge
  always @(negedge clk) begin
    logic        nxt_valid;
    logic [7:0]  nxt_data;
    logic        nxt_last;
    logic        nxt_user;
    logic        nxt_cfg_valid;
    logic [63:0] nxt_cfg_data;
    msg_item_t   head;
    nxt_valid     = in_tvalid;
    nxt_data      = in_tdata;
    nxt_last      = in_tlast;
    nxt_user      = in_tuser;
    nxt_cfg_valid = cfg_valid;
    nxt_cfg_data  = cfg_data;
    if (rst_n) begin
      if (in_tvalid && in_took)
        nxt_valid = 1'b0;
      if (cfg_valid && cfg_took)
        nxt_cfg_valid = 1'b0;
      if (!nxt_valid && !nxt_cfg_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          head = pending_items[0];
          if (!(head.is_seed_write || head.wait_idle) ||
              (expected_hashes.size() == 0 && quiet_cycles >= SETTLE_CYCLES)) begin
            void'(pending_items.pop_front());
            if (head.is_seed_write) begin
              nxt_cfg_valid = 1'b1;
              nxt_cfg_data  = head.seed_value;
            end else if (!head.wait_idle) begin
              nxt_valid = 1'b1;
              nxt_data  = head.data_byte;
              nxt_last  = head.last_byte;
              nxt_user  = head.no_data;
              if (burst_left == 0) begin
                gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 4);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(0, 12);
              end else begin
                burst_left--;
              end
            end
          end
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
    in_tlast  <= nxt_last;
    in_tuser  <= nxt_user;
    cfg_valid <= nxt_cfg_valid;
    cfg_data  <= nxt_cfg_data;
  end

  // receiver: stall pattern switches between open, coin-flip and sparse
  always @(negedge clk) begin
    logic rdy;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_t'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(20, 150);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      RX_OPEN: begin
        rdy = 1'b1;
      end
      RX_COIN: begin
        rdy = 1'($urandom_range(0, 1));
      end
      default: begin
        if (rx_holdoff == 0) begin
          rdy        = 1'b1;
          rx_holdoff = $urandom_range(0, 24);
        end else begin
          rdy = 1'b0;
          rx_holdoff--;
        end
      end
    endcase
    out_tready <= rdy;
  end

  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int          sent;
    int          msg_len;
    bit          tail_no_data;
    logic [63:0] phase_seed;

    // directed: empty message, single byte, no-data items, full word,
    // seed change mid-message, seven-byte tail closed by a no-data item
    push_seed('1);
    push_byte(8'h5A, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b0);
    push_byte(8'hC3, 1'b0, 1'b1);
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'h80, 1'b1, 1'b0);
    for (int i = 0; i < 8; i++)
      push_byte(8'h01 << i, i == 7, 1'b0);
    push_byte(8'h11, 1'b0, 1'b0);
    push_byte(8'h22, 1'b0, 1'b0);
    push_byte(8'h33, 1'b0, 1'b0);
    push_seed('0);
    push_byte(8'h44, 1'b1, 1'b0);
    push_seed({$urandom, $urandom});
    for (int i = 0; i < 7; i++)
      push_byte(8'(8'hFE - i), 1'b0, 1'b0);
    push_byte(8'hAA, 1'b1, 1'b1);

    // random: several seed phases, mostly well-formed messages
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1:       phase_seed = '0;
        2:       phase_seed = '1;
        default: phase_seed = {$urandom, $urandom};
      endcase
      push_seed(phase_seed);
      sent = 0;
      while (sent < 100) begin
        if ($urandom_range(0, 19) == 0) begin
          push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
          sent++;
        end else begin
          case ($urandom_range(0, 9))
            0, 1:    msg_len = 8 * $urandom_range(1, 4);
            2:       msg_len = $urandom_range(25, 60);
            default: msg_len = $urandom_range(1, 15);
          endcase
          tail_no_data = ($urandom_range(0, 5) == 0);
          for (int i = 0; i < msg_len; i++) begin
            if ($urandom_range(0, 15) == 0)
              push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            if ($urandom_range(0, 60) == 0)
              push_seed({$urandom, $urandom});
            push_byte(8'($urandom_range(0, 255)), (i == msg_len - 1) && !tail_no_data,
                      1'b0);
            sent++;
          end
          if (tail_no_data) begin
            push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            sent++;
          end
        end
        if ($urandom_range(0, 25) == 0)
          push_pause();
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    forever begin
      @(posedge clk);
      if (pending_items.size() == 0 && !in_tvalid && !cfg_valid)
        break;
    end
    forever begin
      @(negedge clk);
      if (expected_hashes.size() == 0)
        break;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (expected_hashes.size() != 0)
      report_mismatch("hashes never produced", expected_hashes.size(), '0);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
